@@ rtl/cba_pkg.sv @@
package cba_pkg;

    localparam int DiskBlocks = 128;
    localparam int DirEntries = 16;
    localparam int IdBits     = 8;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_MAP    = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_DIR_FULL   = 3'd3;
    localparam logic [2:0] ST_DUPLICATE  = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

    // Command as it travels from the front end to the executor.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] file_id;
        logic [7:0] run_length;
        logic [6:0] block_index;
        logic       block_free;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] run_start;
        logic [7:0] run_blocks;
    } res_t;

endpackage

@@ rtl/contiguous_block_allocator.sv @@
// First-fit contiguous block allocator.
// Commands arrive on a valid/ready channel (cmd, file_id, run_length,
// block_index, block_free); one result per command leaves on a second
// valid/ready channel (status, run_start, run_blocks), in order.
// A two-entry queue parts the command channel from the executor, so up to
// two commands are taken while the executor is busy.
// Create walks the directory at one entry a cycle, then scans the free map
// one block a cycle and marks the found run one block a cycle. Delete walks
// the directory, then frees the file's run; a map write or an unused
// command goes straight to its result. The executor handles one command
// at a time; its cost is set by the entry-serial directory walk and the
// block-serial map walk. Reset marks every block free, empties the
// directory and sets blocks_in_use to 128. If the receiver stalls, the
// result is held and the executor waits after finishing its next command;
// the queue then fills. blocks_in_use is written over the APB port at
// address 0; the user must write it only while idle, as the block itself
// does not enforce this.
module contiguous_block_allocator #(
    parameter int DISK_BLOCKS = cba_pkg::DiskBlocks,
    parameter int DIR_ENTRIES = cba_pkg::DirEntries,
    parameter int ID_BITS     = cba_pkg::IdBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  file_id,
    input  logic [7:0]  run_length,
    input  logic [6:0]  block_index,
    input  logic        block_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [6:0]  run_start,
    output logic [7:0]  run_blocks
);

    localparam logic [1:0] REG_BLOCKS_IN_USE = 2'd0;

    logic [7:0]    blocks_in_use_reg;
    logic          q_valid;
    logic          q_ready;
    cba_pkg::cmd_t q_cmd;
    cba_pkg::res_t res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BLOCKS_IN_USE) ? {24'd0, blocks_in_use_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= 8'd128;
        end
        else if (psel && penable && pwrite && paddr == REG_BLOCKS_IN_USE)
        begin
            blocks_in_use_reg <= pwdata[7:0];
        end
    end

    cba_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (in_valid),
        .ready       (in_ready),
        .cmd         (cmd),
        .file_id     (file_id),
        .run_length  (run_length),
        .block_index (block_index),
        .block_free  (block_free),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd)
    );

    cba_exec #(
        .DISK_BLOCKS (DISK_BLOCKS),
        .DIR_ENTRIES (DIR_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .blocks_in_use (blocks_in_use_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .res_valid     (out_valid),
        .res_ready     (out_ready),
        .res           (res)
    );

    assign status     = res.status;
    assign run_start  = res.run_start;
    assign run_blocks = res.run_blocks;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != cba_pkg::ST_OK |-> run_start == 7'd0 && run_blocks == 8'd0)
        else $error("error result carries a run");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cba_pkg::ST_OK && run_blocks != 8'd0
        |-> run_blocks <= 8'(DISK_BLOCKS))
        else $error("run longer than disk");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");

endmodule

@@ rtl/cba_front.sv @@
module cba_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  logic [1:0]      cmd,
    input  logic [7:0]      file_id,
    input  logic [7:0]      run_length,
    input  logic [6:0]      block_index,
    input  logic            block_free,
    output logic            q_valid,
    input  logic            q_ready,
    output cba_pkg::cmd_t   q_cmd
);

    // Two-entry queue between the channel and the executor.
    cba_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;
    cba_pkg::cmd_t in_cmd;

    always_comb
    begin
        in_cmd.cmd         = cmd;
        in_cmd.file_id     = file_id;
        in_cmd.run_length  = run_length;
        in_cmd.block_index = block_index;
        in_cmd.block_free  = block_free;
    end

    assign ready   = (count_reg != 2'd2);
    assign push    = valid && ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/cba_exec.sv @@
module cba_exec #(
    parameter int DISK_BLOCKS = cba_pkg::DiskBlocks,
    parameter int DIR_ENTRIES = cba_pkg::DirEntries,
    parameter int ID_BITS     = cba_pkg::IdBits
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      blocks_in_use,
    input  logic            q_valid,
    output logic            q_ready,
    input  cba_pkg::cmd_t   q_cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output cba_pkg::res_t   res
);

    localparam int BW = $clog2(DISK_BLOCKS);
    localparam int EW = $clog2(DIR_ENTRIES);
    localparam int CW = BW + 1;
    localparam int DW = EW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIR    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [DISK_BLOCKS-1:0] free_map_reg;
    logic [DIR_ENTRIES-1:0] entry_valid_reg;
    logic [ID_BITS-1:0]     entry_file_reg   [DIR_ENTRIES];
    logic [BW-1:0]          entry_start_reg  [DIR_ENTRIES];
    logic [7:0]             entry_length_reg [DIR_ENTRIES];

    logic [2:0]    state_reg;
    cba_pkg::cmd_t c_reg;
    logic [DW-1:0] dir_reg;
    logic          hit_reg;
    logic [EW-1:0] hit_slot_reg;
    logic          free_slot_ok_reg;
    logic [EW-1:0] free_slot_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] limit_reg;
    logic [8:0]    run_reg;
    logic [8:0]    left_reg;
    logic          fill_val_reg;
    cba_pkg::res_t acc_reg;
    cba_pkg::res_t res_reg;
    logic          res_valid_reg;

    logic [EW-1:0]      dslot;
    logic [BW-1:0]      bpos;
    logic [8:0]         run_next;
    logic [CW-1:0]      n_lim;

    assign dslot    = dir_reg[EW-1:0];
    assign bpos     = pos_reg[BW-1:0];
    assign run_next = free_map_reg[bpos] ? run_reg + 9'd1 : 9'd0;
    assign n_lim    = ({1'b0, blocks_in_use} > 9'(DISK_BLOCKS)) ? CW'(DISK_BLOCKS)
                                                                 : CW'(blocks_in_use);
    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
        end
        else if (state_reg == S_FILL && left_reg != 9'd0 && pos_reg < CW'(DISK_BLOCKS))
        begin
            free_map_reg[bpos] <= fill_val_reg;
        end
        else if (state_reg == S_IDLE && q_valid && q_cmd.cmd == cba_pkg::CMD_MAP
                 && {1'b0, q_cmd.block_index} < 8'(DISK_BLOCKS))
        begin
            free_map_reg[q_cmd.block_index[BW-1:0]] <= q_cmd.block_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
            entry_valid_reg <= '0;
        end
        else
        begin
            // The result register only changes once the previous transfer has gone.
            if (state_reg == S_DONE && (!res_valid_reg || res_ready))
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= acc_reg;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        c_reg            <= q_cmd;
                        dir_reg          <= '0;
                        hit_reg          <= 1'b0;
                        free_slot_ok_reg <= 1'b0;
                        pos_reg          <= '0;
                        run_reg          <= '0;
                        limit_reg        <= n_lim;
                        acc_reg          <= '0;
                        if (q_cmd.cmd == cba_pkg::CMD_CREATE && q_cmd.run_length == 8'd0)
                        begin
                            acc_reg.status <= cba_pkg::ST_BAD_LENGTH;
                            state_reg      <= S_DONE;
                        end
                        else if (q_cmd.cmd == cba_pkg::CMD_CREATE
                                 || q_cmd.cmd == cba_pkg::CMD_DELETE)
                        begin
                            state_reg <= S_DIR;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DIR:
                begin
                    // One directory entry per cycle.
                    if (dir_reg == DW'(DIR_ENTRIES))
                    begin
                        if (c_reg.cmd == cba_pkg::CMD_DELETE)
                        begin
                            if (!hit_reg)
                            begin
                                acc_reg.status <= cba_pkg::ST_NOT_FOUND;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                entry_valid_reg[hit_slot_reg] <= 1'b0;
                                pos_reg      <= CW'(entry_start_reg[hit_slot_reg]);
                                left_reg     <= {1'b0, entry_length_reg[hit_slot_reg]};
                                fill_val_reg <= 1'b1;
                                acc_reg.run_start  <= 7'(entry_start_reg[hit_slot_reg]);
                                acc_reg.run_blocks <= entry_length_reg[hit_slot_reg];
                                state_reg    <= S_FILL;
                            end
                        end
                        else if (hit_reg)
                        begin
                            acc_reg.status <= cba_pkg::ST_DUPLICATE;
                            state_reg      <= S_DONE;
                        end
                        else if (!free_slot_ok_reg)
                        begin
                            acc_reg.status <= cba_pkg::ST_DIR_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        if (entry_valid_reg[dslot]
                            && entry_file_reg[dslot] == c_reg.file_id[ID_BITS-1:0]
                            && !hit_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= dslot;
                        end
                        if (!entry_valid_reg[dslot] && !free_slot_ok_reg)
                        begin
                            free_slot_ok_reg <= 1'b1;
                            free_slot_reg    <= dslot;
                        end
                        dir_reg <= dir_reg + DW'(1);
                    end
                end
                S_SCAN:
                begin
                    // First fit: one block per cycle, stop on a fit or at limit_reg.
                    if (pos_reg >= limit_reg)
                    begin
                        acc_reg.status <= cba_pkg::ST_NO_SPACE;
                        state_reg      <= S_DONE;
                    end
                    else if (run_next == {1'b0, c_reg.run_length})
                    begin
                        pos_reg   <= pos_reg + CW'(1) - CW'(c_reg.run_length);
                        left_reg  <= {1'b0, c_reg.run_length};
                        fill_val_reg <= 1'b0;
                        entry_valid_reg[free_slot_reg]  <= 1'b1;
                        entry_file_reg[free_slot_reg]   <= c_reg.file_id[ID_BITS-1:0];
                        entry_start_reg[free_slot_reg]  <=
                            BW'(pos_reg + CW'(1) - CW'(c_reg.run_length));
                        entry_length_reg[free_slot_reg] <= c_reg.run_length;
                        acc_reg.run_start  <= 7'(pos_reg + CW'(1) - CW'(c_reg.run_length));
                        acc_reg.run_blocks <= c_reg.run_length;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        run_reg <= run_next;
                        pos_reg <= pos_reg + CW'(1);
                    end
                end
                S_FILL:
                begin
                    if (left_reg == 9'd0 || pos_reg >= CW'(DISK_BLOCKS))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        left_reg <= left_reg - 9'd1;
                        pos_reg  <= pos_reg + CW'(1);
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
